>>> sv/lwts_pkg.sv
// Package for the longest window with target sum block.
// Holds field widths and the sequencer state type; it depends on nothing else.
package lwts_pkg;

   localparam int unsigned MAX_LEN_DEFAULT = 1024;
   localparam int unsigned VALUE_W         = 16;
   localparam int unsigned TARGET_W        = 26;
   localparam int unsigned SUM_W           = TARGET_W + 1;
   localparam int unsigned BEST_W          = 11;
   localparam int unsigned BEST_MAX        = 2047;
   localparam int unsigned REQ_TDATA_W     = 16;
   localparam int unsigned RSP_TDATA_W     = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUB
   } seq_state_type;

endpackage

>>> sv/lwts_store.sv
// Element store: one write port and one registered read port.
// Uses lwts_pkg for the element width.
module lwts_store #(
   parameter int unsigned MAX_LEN = lwts_pkg::MAX_LEN_DEFAULT,
   parameter int unsigned AW      = $clog2(MAX_LEN)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [lwts_pkg::VALUE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [lwts_pkg::VALUE_W-1:0] rd_data
);
   import lwts_pkg::*;

   logic [VALUE_W-1:0] mem [MAX_LEN];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lwts_ctrl.sv
// Sequencer and window datapath: window sum, bounds, best length and result register.
// Uses lwts_pkg; drives the ports of lwts_store.
module lwts_ctrl #(
   parameter int unsigned MAX_LEN = lwts_pkg::MAX_LEN_DEFAULT,
   parameter int unsigned AW      = $clog2(MAX_LEN),
   parameter int unsigned CW      = $clog2(MAX_LEN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [lwts_pkg::TARGET_W-1:0] csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lwts_pkg::VALUE_W-1:0]  req_value,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lwts_pkg::BEST_W-1:0]   rsp_best,
   output logic                          rsp_ovf,
   output logic                          mem_wr_en,
   output logic [AW-1:0]                 mem_wr_addr,
   output logic [lwts_pkg::VALUE_W-1:0]  mem_wr_data,
   output logic                          mem_rd_en,
   output logic [AW-1:0]                 mem_rd_addr,
   input  logic [lwts_pkg::VALUE_W-1:0]  mem_rd_data
);
   import lwts_pkg::*;

   localparam int unsigned XW = CW + BEST_W;

   seq_state_type       state_ff, state_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CW-1:0]       start_ff, start_in;
   logic [CW-1:0]       end_ff, end_in;
   logic [CW-1:0]       best_ff, best_in;
   logic                ovf_ff, ovf_in;
   logic                last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BEST_W-1:0]   rsp_best_ff, rsp_best_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic [CW-1:0]       win_len;
   logic [CW-1:0]       best_next;
   logic [XW-1:0]       best_wide;
   logic                shrink;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         sum_ff       <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         sum_ff       <= sum_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_best_ff <= rsp_best_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      target_in    = csr_wr_en ? csr_wr_data : target_ff;
      sum_in       = sum_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_best_in  = rsp_best_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      req_tready   = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = end_ff[AW-1:0];
      mem_wr_data  = req_value;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = start_ff[AW-1:0];

      win_len   = end_ff - start_ff;
      shrink    = (sum_ff > {1'b0, target_ff}) && (start_ff < end_ff);
      best_next = ((sum_ff == {1'b0, target_ff}) && (win_len > best_ff)) ? win_len : best_ff;
      best_wide = XW'(best_next);

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               last_in  = req_tlast;
               state_in = ST_CHECK;
               if (end_ff == CW'(MAX_LEN)) begin
                  ovf_in = 1'b1;
               end else begin
                  mem_wr_en = 1'b1;
                  end_in    = end_ff + CW'(1);
                  sum_in    = sum_ff + SUM_W'(req_value);
               end
            end
         end
         ST_CHECK: begin
            if (shrink) begin
               mem_rd_en = 1'b1;
               state_in  = ST_SUB;
            end else begin
               best_in = best_next;
               if (!last_ff) begin
                  state_in = ST_IDLE;
               end else if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  rsp_best_in  = (best_wide > XW'(BEST_MAX)) ? BEST_W'(BEST_MAX)
                                                             : best_wide[BEST_W-1:0];
                  rsp_ovf_in   = ovf_ff;
                  sum_in       = '0;
                  start_in     = '0;
                  end_in       = '0;
                  best_in      = '0;
                  ovf_in       = 1'b0;
                  last_in      = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_SUB: begin
            sum_in   = sum_ff - SUM_W'(mem_rd_data);
            start_in = start_ff + CW'(1);
            state_in = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_best   = rsp_best_ff;
   assign rsp_ovf    = rsp_ovf_ff;

endmodule

>>> sv/longest_window_with_target_sum.sv
// Top level of the longest window with target sum block.
// Uses lwts_pkg and instantiates lwts_ctrl and lwts_store.
//
// Words of a sequence arrive on the req_ channel, one element each, with
// req_tlast on the final element. Each element is written into the element
// store and added to the window sum; the oldest elements are then dropped
// while the sum exceeds the target, and the longest window whose sum equals
// the target is recorded. The word with req_tlast yields one rsp_ word
// carrying that length (saturated at 2047) and the overflow flag, after which
// the sequence state is cleared. Elements beyond MAX_LEN are dropped and flag
// overflow.
// Each element is accepted in the idle state and then checked; every element
// dropped from the window adds a store read followed by a subtraction, and
// every element leaves the window at most once. No new element is accepted
// until the checks for the last one are done. One result word is held in an
// output register; while it waits, further elements are accepted, and the
// next result waits until it is taken.
// Synchronous reset clears the target to zero and empties the sequence state.
// The csr_ port writes the target in any cycle; it should only change while idle.
module longest_window_with_target_sum #(
   parameter int unsigned MAX_LEN = lwts_pkg::MAX_LEN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [lwts_pkg::TARGET_W-1:0]    csr_wr_data,     // target_sum
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lwts_pkg::REQ_TDATA_W-1:0] req_tdata,       // value [15:0]
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lwts_pkg::RSP_TDATA_W-1:0] rsp_tdata,       // best_length [10:0], zeros
   output logic                             rsp_tuser        // overflow
);
   import lwts_pkg::*;

   localparam int unsigned AW = $clog2(MAX_LEN);
   localparam int unsigned CW = $clog2(MAX_LEN + 1);

   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [VALUE_W-1:0]  mem_wr_data;
   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic [VALUE_W-1:0]  mem_rd_data;
   logic [BEST_W-1:0]   rsp_best;

   lwts_ctrl #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW),
      .CW      (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_value   (req_tdata[VALUE_W-1:0]),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_best    (rsp_best),
      .rsp_ovf     (rsp_tuser),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   lwts_store #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_best);

endmodule

>>> test/longest_window_with_target_sum_tb.sv
// Self-checking testbench for the longest window with target sum block.
// Depends on lwts_pkg and longest_window_with_target_sum; predicts each result
// word from its own window model or takes it from the directed rows, and checks it against the rsp_ stream.
`timescale 1ns / 1ps

module longest_window_with_target_sum_tb;
   import lwts_pkg::*;

   localparam int unsigned STORE_DEPTH  = MAX_LEN_DEFAULT;
   localparam int unsigned TARGET_MAX   = (1 << TARGET_W) - 1;
   localparam int unsigned SETTLE_WAIT  = 16;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned PHASES       = 9;
   localparam int unsigned PHASE_WORDS  = 24;
   localparam int unsigned FULL_RUN     = STORE_DEPTH + 2;

   typedef struct packed {
      logic [BEST_W-1:0] best;
      logic              overflow;
   } seq_result_type;

   typedef enum logic {
      ROW_WORD,
      ROW_TARGET
   } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [TARGET_W-1:0] data;
      logic              last;
      logic              typed;
      logic [BEST_W-1:0] best;
      logic              overflow;
   } directed_row_type;

   localparam int unsigned NUM_ROWS = 26;
   localparam directed_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      '{ROW_WORD,   26'd0,          1'b1, 1'b1, 11'd1, 1'b0},
      '{ROW_WORD,   26'hFFFF,       1'b1, 1'b1, 11'd0, 1'b0},
      '{ROW_WORD,   26'd0,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd0,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd0,          1'b1, 1'b1, 11'd3, 1'b0},
      '{ROW_WORD,   26'd5,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd0,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd0,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd7,          1'b1, 1'b0, 11'd0, 1'b0},
      '{ROW_TARGET, 26'd10,         1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd3,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd7,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd0,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd4,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd6,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd10,         1'b1, 1'b0, 11'd0, 1'b0},
      '{ROW_TARGET, 26'h3FFFFFF,    1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'hFFFF,       1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'hFFFF,       1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'hFFFF,       1'b1, 1'b1, 11'd0, 1'b0},
      '{ROW_TARGET, 26'hFFFF,       1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd1,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'hFFFF,       1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'd0,          1'b0, 1'b0, 11'd0, 1'b0},
      '{ROW_WORD,   26'hFFFF,       1'b1, 1'b0, 11'd0, 1'b0},
      '{ROW_TARGET, 26'd0,          1'b0, 1'b0, 11'd0, 1'b0}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [TARGET_W-1:0]    csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   logic [VALUE_W-1:0]  elem_mem [0:STORE_DEPTH-1];
   logic [SUM_W-1:0]    win_sum;
   int unsigned         win_start;
   int unsigned         win_end;
   int unsigned         best_len;
   logic                ovf_seen;
   logic [TARGET_W-1:0] target_reg;

   seq_result_type expected_best [$];
   int unsigned mismatches;
   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;
   logic        hold_pending;

   longest_window_with_target_sum i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
   endtask

   function automatic void clear_window();
      win_sum   = '0;
      win_start = 0;
      win_end   = 0;
      best_len  = 0;
      ovf_seen  = 1'b0;
   endfunction

   function automatic logic track_window(input logic [VALUE_W-1:0] v, input logic l,
                                         output seq_result_type res);
      int unsigned run_len;
      if (win_end >= STORE_DEPTH) begin
         ovf_seen = 1'b1;
      end else begin
         elem_mem[win_end] = v;
         win_end++;
         win_sum += v;
         while (win_sum > target_reg && win_start < win_end) begin
            win_sum -= elem_mem[win_start];
            win_start++;
         end
         if (win_sum == target_reg) begin
            run_len = win_end - win_start;
            if (run_len > best_len) begin
               best_len = run_len;
            end
         end
      end
      res.best     = BEST_W'(best_len > BEST_MAX ? BEST_MAX : best_len);
      res.overflow = ovf_seen;
      if (l) begin
         clear_window();
      end
      return l;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_element(input int unsigned span);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) begin
         return '0;
      end else if (roll < 85) begin
         return VALUE_W'($urandom_range(span / 4 + 1));
      end else if (roll < 95) begin
         return VALUE_W'($urandom_range(span));
      end
      return VALUE_W'($urandom);
   endfunction

   function automatic logic [TARGET_W-1:0] pick_target(input int unsigned phase);
      case (phase)
         0: begin
            return '0;
         end
         4: begin
            return TARGET_W'(TARGET_MAX);
         end
         default: begin
            case ($urandom_range(3))
               0: return TARGET_W'($urandom_range(1, 40));
               1: return TARGET_W'($urandom_range(41, 3000));
               2: return TARGET_W'($urandom_range(3001, 300000));
               default: return TARGET_W'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic send_word(input logic [VALUE_W-1:0] v, input logic l,
                            input logic use_typed, input seq_result_type typed_res);
      seq_result_type pred;
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      if (track_window(v, l, pred)) begin
         expected_best.push_back(use_typed ? typed_res : pred);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_best.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_target(input logic [TARGET_W-1:0] t);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      target_reg = t;
   endtask

   initial begin
      int unsigned hold_left;
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_best.size() == 0) begin
               report_mismatch("unexpected result word, best length", 0, rsp_tdata);
            end else begin
               seq_result_type want;
               want = expected_best.pop_front();
               if (rsp_tdata !== RSP_TDATA_W'(want.best)) begin
                  report_mismatch("best length", want.best, rsp_tdata);
               end
               if (rsp_tuser !== want.overflow) begin
                  report_mismatch("overflow flag", want.overflow, rsp_tuser);
               end
            end
         end
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending <= 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      seq_result_type   typed_res;
      seq_result_type   no_res;
      directed_row_type row;
      int unsigned      span;
      int unsigned      phase_words;
      int unsigned      seq_len;

      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      hold_pending   = 1'b0;
      mismatches     = 0;
      send_gap_pct   = 12;
      recv_stall_pct = 83;
      no_res         = '0;
      target_reg     = '0;
      clear_window();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_TARGET) begin
            write_target(row.data);
         end else begin
            typed_res.best     = row.best;
            typed_res.overflow = row.overflow;
            send_word(VALUE_W'(row.data), row.last, row.typed, typed_res);
         end
      end

      // With a zero target every zero extends the window, so the store fills
      // completely; the extra words must be dropped even though they are large.
      typed_res.best     = BEST_W'(STORE_DEPTH);
      typed_res.overflow = 1'b1;
      for (int i = 1; i <= FULL_RUN; i++) begin
         send_word(i > STORE_DEPTH ? '1 : '0, i == FULL_RUN, 1'b1, typed_res);
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            send_gap_pct   = 83;
            recv_stall_pct = 12;
         end else if (p == 6) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         write_target(pick_target(p));
         if (p == 6) begin
            hold_pending <= 1'b1;
         end
         span = target_reg < 65535 ? target_reg : 65535;
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            seq_len = ($urandom_range(99) < 85) ? $urandom_range(1, 12)
                                                : $urandom_range(13, 80);
            for (int i = 1; i <= seq_len; i++) begin
               send_word(pick_element(span), i == seq_len, 1'b0, no_res);
            end
            phase_words += seq_len;
         end
      end

      drain_results();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/lwts_pkg.sv
sv/lwts_store.sv
sv/lwts_ctrl.sv
sv/longest_window_with_target_sum.sv
test/longest_window_with_target_sum_tb.sv
